FILE: src/crsf_rx_pkg.sv
// shared types, constants and the crc8 step of the crsf frame receiver
// no dependencies; every other file imports this package
package crsf_rx_pkg;

  localparam int CHANNELS     = 16;
  localparam int CHANNEL_BITS = 11;
  localparam int STATS_BYTES  = 10;
  localparam int STORE_BYTES  = 64;

  localparam int BYTE_W  = 6;
  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int ACC_W   = CHANNEL_BITS + 7;
  localparam int NB_W    = $clog2(CHANNEL_BITS + 8);
  localparam int CH_W    = $clog2(CHANNELS + 1);
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int VALUE_W = 11;
  localparam int REG_W   = 2;

  localparam logic [7:0] CRC_POLY = 8'hD5;

  localparam logic [7:0]        SYNC_RESET    = 8'd200;
  localparam logic [7:0]        CHAN_RESET    = 8'd22;
  localparam logic [7:0]        STATS_RESET   = 8'd20;
  localparam logic [BYTE_W-1:0] LONGEST_RESET = 6'd62;
  localparam logic [7:0]        MIN_LENGTH    = 8'd2;

  localparam logic [REG_W-1:0] REG_SYNC    = 2'd0;
  localparam logic [REG_W-1:0] REG_CHAN    = 2'd1;
  localparam logic [REG_W-1:0] REG_STATS   = 2'd2;
  localparam logic [REG_W-1:0] REG_LONGEST = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ERR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATS = 2'd2;

  typedef enum logic [1:0] {PH_HUNT, PH_LEN, PH_BODY} phase_e;
  typedef enum logic [1:0] {CMD_ERR, CMD_CHAN, CMD_STATS} cmd_e;
  typedef enum logic [2:0] {B_IDLE, B_ERR, B_RD, B_DATA, B_EMIT} back_e;

  typedef struct packed {
    cmd_e              kind;
    logic              bank;
    logic [BYTE_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic               last;
  } res_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // msb-first crc8, initial value supplied by caller, no final xor
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: src/crsf_rx_cmdq.sv
// two-entry queue of frame commands between the front and the back
// depends on crsf_rx_pkg
module crsf_rx_cmdq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  crsf_rx_pkg::cmd_t   data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output crsf_rx_pkg::cmd_t   data_o
);
  import crsf_rx_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/crsf_rx_resq.sv
// two-entry result queue that drives the output side of the receiver
// depends on crsf_rx_pkg
module crsf_rx_resq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  crsf_rx_pkg::res_t   data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output crsf_rx_pkg::res_t   data_o
);
  import crsf_rx_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/crsf_rx_front.sv
// front end: config registers, sync hunt, length check, crc8 and frame store writes
// depends on crsf_rx_pkg; issues frame commands to crsf_rx_cmdq
module crsf_rx_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [crsf_rx_pkg::REG_W-1:0]         cfg_index_i,
  input  logic [7:0]                            cfg_data_i,
  input  logic                                  push,
  output logic                                  full,
  input  logic [7:0]                            rx_byte_i,
  output crsf_rx_pkg::store_wr_t                store_wr_o,
  output logic                                  cmd_push_o,
  output crsf_rx_pkg::cmd_t                     cmd_o,
  input  logic                                  cmdq_full_i,
  input  crsf_rx_pkg::release_t                 release_i
);
  import crsf_rx_pkg::*;

  logic [7:0]        sync_q, chan_type_q, stats_type_q;
  logic [BYTE_W-1:0] longest_q;

  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] len_q, cnt_q;
  logic [7:0]        crc_q, type_q;
  logic              wbank_q;
  logic [1:0]        busy_q, busy_d;

  logic       accept;
  logic       body_data;
  logic       len_ok;
  logic [7:0] crc_next;
  logic       crc_end;
  logic       crc_bad;

  assign cfg_ready_o = 1'b1;
  assign full        = cmdq_full_i || busy_q[wbank_q];
  assign accept      = push && !full;
  assign body_data   = ({1'b0, cnt_q} + 7'd1) < {1'b0, len_q};
  assign len_ok      = (rx_byte_i >= MIN_LENGTH) && (rx_byte_i <= {2'b00, longest_q});
  assign crc_next    = crc8_step(crc_q, rx_byte_i);
  assign crc_bad     = (rx_byte_i != crc_q);

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_HUNT: begin
        if (accept && rx_byte_i == sync_q) begin
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (accept) begin
          phase_d = len_ok ? PH_BODY : PH_HUNT;
        end
      end
      PH_BODY: begin
        if (accept && !body_data) begin
          phase_d = PH_HUNT;
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // store writes and frame commands
  always_comb begin
    crc_end         = accept && (phase_q == PH_BODY) && !body_data;
    store_wr_o.en   = accept && (phase_q == PH_BODY) && body_data &&
                      ({1'b0, cnt_q} < 7'(STORE_BYTES));
    store_wr_o.bank = wbank_q;
    store_wr_o.addr = cnt_q[ADDR_W-1:0];
    store_wr_o.data = rx_byte_i;
    cmd_o.bank      = wbank_q;
    cmd_o.count     = cnt_q;
    cmd_push_o      = 1'b0;
    cmd_o.kind      = CMD_ERR;
    if (crc_end) begin
      // a channels frame wins over statistics when both codes match
      if (crc_bad) begin
        cmd_push_o = 1'b1;
        cmd_o.kind = CMD_ERR;
      end else if (type_q == chan_type_q) begin
        cmd_push_o = 1'b1;
        cmd_o.kind = CMD_CHAN;
      end else if (type_q == stats_type_q) begin
        cmd_push_o = 1'b1;
        cmd_o.kind = CMD_STATS;
      end
    end
  end

  // bank hold flags
  always_comb begin
    busy_d = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    // the bank now holds a frame until the back end releases it
    if (cmd_push_o && cmd_o.kind != CMD_ERR) begin
      busy_d[wbank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q       <= SYNC_RESET;
      chan_type_q  <= CHAN_RESET;
      stats_type_q <= STATS_RESET;
      longest_q    <= LONGEST_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SYNC:    sync_q       <= cfg_data_i;
        REG_CHAN:    chan_type_q  <= cfg_data_i;
        REG_STATS:   stats_type_q <= cfg_data_i;
        REG_LONGEST: longest_q    <= cfg_data_i[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      cnt_q   <= '0;
      crc_q   <= '0;
      type_q  <= '0;
      wbank_q <= 1'b0;
      busy_q  <= '0;
    end else begin
      phase_q <= phase_d;
      busy_q  <= busy_d;
      if (accept && phase_q == PH_LEN && len_ok) begin
        len_q <= rx_byte_i[BYTE_W-1:0];
        cnt_q <= '0;
        crc_q <= '0;
      end
      if (accept && phase_q == PH_BODY && body_data) begin
        crc_q <= crc_next;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '0) begin
          type_q <= rx_byte_i;
        end
      end
      if (cmd_push_o && cmd_o.kind != CMD_ERR) begin
        wbank_q <= ~wbank_q;
      end
    end
  end

`ifndef SYNTHESIS
  a_wr_free_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_wr_o.en |-> !busy_q[wbank_q])
    else $error("store write into a held bank");
  a_cmd_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o |-> !cmdq_full_i)
    else $error("frame command pushed into a full queue");
  a_release_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    release_i.valid |-> busy_q[release_i.bank])
    else $error("release of a bank that is not held");
  a_busy_after_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push_o && cmd_o.kind != CMD_ERR) |=> busy_q[$past(wbank_q)])
    else $error("bank not held after frame command");
`endif

endmodule

FILE: src/crsf_rx_back.sv
// back end: two-bank frame store, channel unpacking and statistics readout
// depends on crsf_rx_pkg; reads commands from crsf_rx_cmdq, feeds crsf_rx_resq
module crsf_rx_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  crsf_rx_pkg::store_wr_t    store_wr_i,
  input  logic                      cmd_empty_i,
  input  crsf_rx_pkg::cmd_t         cmd_i,
  output logic                      cmd_pop_o,
  input  logic                      res_full_i,
  output logic                      res_push_o,
  output crsf_rx_pkg::res_t         res_o,
  output crsf_rx_pkg::release_t     release_o
);
  import crsf_rx_pkg::*;

  logic [7:0] store_q [2*STORE_BYTES];
  logic [7:0] rdata_q;

  back_e             state_q, state_d;
  cmd_t              cur_q, cur_d;
  logic [BYTE_W-1:0] j_q, j_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [NB_W-1:0]   nb_q, nb_d;

  logic              rd_en;
  logic [ADDR_W:0]   rd_addr;
  logic [BYTE_W:0]   idx;
  logic              in_range;
  logic [7:0]        pbyte;
  logic [CHANNEL_BITS-1:0] chan_val;

  // payload byte j sits at store index j+1; bytes not received this frame read as zero
  assign idx      = {1'b0, j_q} + 7'd1;
  assign in_range = (idx < {1'b0, cur_q.count}) && (idx < 7'(STORE_BYTES));
  assign pbyte    = in_range ? rdata_q : 8'd0;
  assign rd_addr  = {cur_q.bank, idx[ADDR_W-1:0]};
  assign chan_val = acc_q[CHANNEL_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) begin
      store_q[{store_wr_i.bank, store_wr_i.addr}] <= store_wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          state_d = (cmd_i.kind == CMD_ERR) ? B_ERR : B_RD;
        end
      end
      B_ERR: begin
        if (!res_full_i) begin
          state_d = B_IDLE;
        end
      end
      B_RD: state_d = B_DATA;
      B_DATA: begin
        if (cur_q.kind == CMD_CHAN) begin
          state_d = B_EMIT;
        end else if (!res_full_i) begin
          state_d = (j_q == BYTE_W'(STATS_BYTES - 1)) ? B_IDLE : B_RD;
        end
      end
      B_EMIT: begin
        if (nb_q < NB_W'(CHANNEL_BITS)) begin
          state_d = B_RD;
        end else if (!res_full_i && ch_q == CH_W'(CHANNELS - 1)) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_pop_o       = 1'b0;
    res_push_o      = 1'b0;
    res_o.kind      = KIND_ERR;
    res_o.slot      = '0;
    res_o.value     = '0;
    res_o.last      = 1'b1;
    release_o.valid = 1'b0;
    release_o.bank  = cur_q.bank;
    rd_en           = 1'b0;
    cur_d           = cur_q;
    j_d             = j_q;
    ch_d            = ch_q;
    acc_d           = acc_q;
    nb_d            = nb_q;
    case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          j_d       = '0;
          ch_d      = '0;
          acc_d     = '0;
          nb_d      = '0;
        end
      end
      B_ERR: begin
        res_push_o = !res_full_i;
      end
      B_RD: begin
        rd_en = 1'b1;
      end
      B_DATA: begin
        if (cur_q.kind == CMD_CHAN) begin
          // append the byte above the bits still held, lsb first
          acc_d = acc_q | (ACC_W'(pbyte) << nb_q);
          nb_d  = nb_q + NB_W'(8);
          j_d   = j_q + 1'b1;
        end else begin
          res_o.kind  = KIND_STATS;
          res_o.slot  = j_q[SLOT_W-1:0];
          res_o.value = VALUE_W'(pbyte);
          res_o.last  = (j_q == BYTE_W'(STATS_BYTES - 1));
          if (!res_full_i) begin
            res_push_o = 1'b1;
            j_d        = j_q + 1'b1;
            if (res_o.last) begin
              release_o.valid = 1'b1;
            end
          end
        end
      end
      B_EMIT: begin
        res_o.kind  = KIND_CHAN;
        res_o.slot  = SLOT_W'(ch_q);
        res_o.value = VALUE_W'(chan_val);
        res_o.last  = (ch_q == CH_W'(CHANNELS - 1));
        if (nb_q >= NB_W'(CHANNEL_BITS) && !res_full_i) begin
          res_push_o = 1'b1;
          acc_d      = acc_q >> CHANNEL_BITS;
          nb_d       = nb_q - NB_W'(CHANNEL_BITS);
          ch_d       = ch_q + 1'b1;
          if (res_o.last) begin
            release_o.valid = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ch_q    <= '0;
      nb_q    <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      nb_q    <= nb_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    acc_q <= acc_d;
  end

`ifndef SYNTHESIS
  a_res_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");
  a_release_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    release_o.valid |-> (cur_q.kind == CMD_CHAN || cur_q.kind == CMD_STATS))
    else $error("bank released by an error frame");
  a_chan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT) |-> (ch_q < CH_W'(CHANNELS)))
    else $error("channel counter past the last channel");
  a_read_then_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_RD) |=> (state_q == B_DATA))
    else $error("store read not followed by its data step");
`endif

endmodule

FILE: src/crsf_frame_receiver.sv
// top level of the crsf frame receiver: front end, command queue, back end, result queue
// depends on crsf_rx_pkg, crsf_rx_front, crsf_rx_cmdq, crsf_rx_back, crsf_rx_resq
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   config   | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//   input    | push / full              | rx_byte_i
//   results  | empty / pop              | kind_o, slot_o, value_o, last_o
//
// the front end takes input bytes while full is low; full rises only while the
// command queue is full or the store bank for the next frame still awaits readout
// the back end reads each stored byte in a read step then a data step, and emits one result per statistics byte
// or channel value; a checksum error gives one error result; it finishes a frame before it takes the next command
// reset clears the state, pointer and counter registers at once; the frame store needs no clearing pass
// config is always ready; the user must make writes only while the block is idle, the block does not enforce it
module crsf_frame_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [crsf_rx_pkg::REG_W-1:0]  cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     rx_byte_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [crsf_rx_pkg::KIND_W-1:0]  kind_o,
  output logic [crsf_rx_pkg::SLOT_W-1:0]  slot_o,
  output logic [crsf_rx_pkg::VALUE_W-1:0] value_o,
  output logic                           last_o
);
  import crsf_rx_pkg::*;

  store_wr_t store_wr;
  logic      cmd_push, cmdq_full, cmd_empty, cmd_pop;
  cmd_t      cmd_in, cmd_out;
  release_t  bank_release;
  logic      res_push, res_full;
  res_t      res_in, res_out;

  crsf_rx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .store_wr_o  (store_wr),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmdq_full_i (cmdq_full),
    .release_i   (bank_release)
  );

  crsf_rx_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmdq_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  crsf_rx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .store_wr_i  (store_wr),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .release_o   (bank_release)
  );

  crsf_rx_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign kind_o  = res_out.kind;
  assign slot_o  = res_out.slot;
  assign value_o = res_out.value;
  assign last_o  = res_out.last;

endmodule
